/* src/hemu_pkg.sv */
package hemu_pkg;

  // Table sizes
  localparam int VERTEX_DEPTH    = 1024;
  localparam int HALF_EDGE_DEPTH = 8192;
  localparam int FACE_DEPTH      = 4096;
  localparam int COORD_WIDTH     = 32;

  // Index and count widths
  localparam int VIW  = $clog2(VERTEX_DEPTH);
  localparam int EIW  = $clog2(HALF_EDGE_DEPTH);
  localparam int FIW  = $clog2(FACE_DEPTH);
  localparam int VCW  = $clog2(VERTEX_DEPTH + 1);
  localparam int ECW  = $clog2(HALF_EDGE_DEPTH + 1);
  localparam int FCW  = $clog2(FACE_DEPTH + 1);
  localparam int IDXW = 13;

  // Sequencer lengths
  localparam int READ_LAST      = 4;
  localparam int INIT_STEPS     = 18;
  localparam int SFACE_STEPS    = 9;
  localparam int FLIP_STEPS     = 6;
  localparam int SEDGE_STEPS    = 12;
  localparam int STEP_W         = 5;

  typedef enum logic [1:0] {
    MODE_INIT       = 2'd0,
    MODE_SPLIT_FACE = 2'd1,
    MODE_FLIP       = 2'd2,
    MODE_SPLIT_EDGE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

/* src/hemu_if.sv */
interface hemu_in_if import hemu_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [IDXW-1:0]               target_index;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;

  modport source (output valid, input ready, output mode, target_index, point_x, point_y,
                  second_x, second_y, third_x, third_y);
  modport sink (input valid, output ready, input mode, target_index, point_x, point_y,
                second_x, second_y, third_x, third_y);
endinterface

interface hemu_out_if import hemu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] result_index;
  logic [1:0]      status;

  modport source (output valid, input ready, output result_index, status);
  modport sink (input valid, output ready, input result_index, status);
endinterface

/* src/half_edge_mesh_update_top.sv */
// Half-edge triangle mesh engine. One operation per input transfer (init, split face, flip,
// split edge) and one result transfer per operation. The tables live in single-port RAMs,
// one per field, so an operation runs as a short sequencer: a check state for the target
// and free space, a chain of dependent table reads (none for init), then one write step
// per touched half-edge (18 for init, 9 for split face, 6 for flip, 12 for split edge), then
// a done state that hands over the result; a rejected item goes from the check state straight
// to the done state. The chain of dependent reads through the half-edge port and the one
// write per cycle on it set the length of an item. A new item is taken while the previous
// result still waits in the output register.
module half_edge_mesh_update_top import hemu_pkg::*; (
  input logic         clk,
  input logic         rst,
  hemu_in_if.sink     in_ch,
  hemu_out_if.source  out_ch
);

  state_t state, state_next;

  // Captured item
  mode_t                         it_mode;
  logic [IDXW-1:0]               it_t;
  logic signed [COORD_WIDTH-1:0] it_px, it_py, it_sx, it_sy, it_tx, it_ty;

  // Counters
  logic [VCW-1:0] vertex_count;
  logic [ECW-1:0] half_edge_count;
  logic [FCW-1:0] face_count;
  logic [VIW-1:0] inf_vid;

  logic [2:0]        rd_step;
  logic [STEP_W-1:0] wr_step;
  logic              wr_last;

  // Result
  logic [IDXW-1:0] res_idx;
  status_t         res_stat;
  logic [IDXW-1:0] res_idx_next;
  status_t         res_stat_next;
  logic            out_valid;
  logic [IDXW-1:0] out_idx;
  status_t         out_stat;

  // Read-back registers
  logic [EIW-1:0] s_e0, s_e1, s_e2;
  logic [VIW-1:0] s_v0, s_v1, s_v2;
  logic [EIW-1:0] r_et, r_en, r_ep, r_tn, r_tp;
  logic [VIW-1:0] r_a, r_b, r_c, r_d;
  logic [FIW-1:0] r_f0, r_f1;

  // RAM ports
  logic [EIW-1:0] e_addr, e_rd_addr, e_wr_addr;
  logic [FIW-1:0] f_addr, f_rd_addr, f_wr_addr;
  logic [VIW-1:0] v_addr;
  logic           v_we_xy, v_we_e;
  logic [COORD_WIDTH-1:0] v_x, v_y;
  logic [EIW-1:0] v_e;
  logic           e_we_org, e_we_twin, e_we_lnk;
  logic [VIW-1:0] e_org;
  logic [EIW-1:0] e_twin, e_next, e_prev;
  logic [FIW-1:0] e_face;
  logic           f_we_e, f_we_inf;
  logic [EIW-1:0] f_e;
  logic           f_inf;
  logic [VIW-1:0] eorg_q;
  logic [EIW-1:0] etwin_q, enext_q, eprev_q, fedge_q;
  logic [FIW-1:0] eface_q;
  logic           finf_q;

  logic [VIW-1:0] vbase;
  logic [EIW-1:0] ebase;
  logic [FIW-1:0] fbase;
  logic [VIW-1:0] vo [4];
  logic [EIW-1:0] eo [INIT_STEPS];
  logic [FIW-1:0] fo [4];
  logic [EIW-1:0] te;
  logic [FIW-1:0] tf;
  logic           sf_inf;
  logic           room_init, room_split;

  assign vbase = vertex_count[VIW-1:0];
  assign ebase = half_edge_count[EIW-1:0];
  assign fbase = face_count[FIW-1:0];
  assign te    = it_t[EIW-1:0];
  assign tf    = it_t[FIW-1:0];

  // New-entry indices relative to the fill counts
  always_comb begin
    for (int i = 0; i < INIT_STEPS; i++) begin
      eo[i] = ebase + EIW'(i);
    end
    for (int i = 0; i < 4; i++) begin
      vo[i] = vbase + VIW'(i);
      fo[i] = fbase + FIW'(i);
    end
  end

  // Free space checks
  assign room_init =
    (({1'b0, vertex_count} + (VCW+1)'(4)) <= (VCW+1)'(VERTEX_DEPTH)) &&
    (({1'b0, half_edge_count} + (ECW+1)'(18)) <= (ECW+1)'(HALF_EDGE_DEPTH)) &&
    (({1'b0, face_count} + (FCW+1)'(4)) <= (FCW+1)'(FACE_DEPTH));
  assign room_split =
    (({1'b0, vertex_count} + (VCW+1)'(1)) <= (VCW+1)'(VERTEX_DEPTH)) &&
    (({1'b0, half_edge_count} + (ECW+1)'(6)) <= (ECW+1)'(HALF_EDGE_DEPTH)) &&
    (({1'b0, face_count} + (FCW+1)'(2)) <= (FCW+1)'(FACE_DEPTH));

  // Rebuilt face touches the infinite vertex
  assign sf_inf = (s_v0 == inf_vid) || (s_v1 == inf_vid) ||
                  (vertex_count == VCW'(inf_vid));

  // Status and result, evaluated in the check cycle
  always_comb begin
    res_stat_next = STAT_OK;
    res_idx_next  = '0;
    case (it_mode)
      MODE_INIT: begin
        if (!room_init) res_stat_next = STAT_FULL;
        else res_idx_next = IDXW'(fbase);
      end
      MODE_SPLIT_FACE: begin
        if (it_t >= face_count) res_stat_next = STAT_BAD_INDEX;
        else if (!room_split) res_stat_next = STAT_FULL;
        else res_idx_next = IDXW'(vbase);
      end
      MODE_FLIP: begin
        if ({1'b0, it_t} >= half_edge_count) res_stat_next = STAT_BAD_INDEX;
        else res_idx_next = it_t;
      end
      MODE_SPLIT_EDGE: begin
        if ({1'b0, it_t} >= half_edge_count) res_stat_next = STAT_BAD_INDEX;
        else if (!room_split) res_stat_next = STAT_FULL;
        else res_idx_next = IDXW'(vbase);
      end
      default: res_stat_next = STAT_OK;
    endcase
  end

  // Last write step per operation
  always_comb begin
    case (it_mode)
      MODE_INIT:       wr_last = (wr_step == STEP_W'(INIT_STEPS - 1));
      MODE_SPLIT_FACE: wr_last = (wr_step == STEP_W'(SFACE_STEPS - 1));
      MODE_FLIP:       wr_last = (wr_step == STEP_W'(FLIP_STEPS - 1));
      MODE_SPLIT_EDGE: wr_last = (wr_step == STEP_W'(SEDGE_STEPS - 1));
      default:         wr_last = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_ch.valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (res_stat_next != STAT_OK) state_next = ST_DONE;
        else if (it_mode == MODE_INIT) state_next = ST_WRITE;
        else state_next = ST_READ;
      end
      ST_READ:  if (rd_step == 3'(READ_LAST)) state_next = ST_WRITE;
      ST_WRITE: if (wr_last) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign in_ch.ready = (state == ST_IDLE);

  // Item capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      it_mode <= mode_t'(in_ch.mode);
      it_t    <= in_ch.target_index;
      it_px   <= in_ch.point_x;
      it_py   <= in_ch.point_y;
      it_sx   <= in_ch.second_x;
      it_sy   <= in_ch.second_y;
      it_tx   <= in_ch.third_x;
      it_ty   <= in_ch.third_y;
    end
    if (state == ST_CHECK) begin
      res_idx  <= res_idx_next;
      res_stat <= res_stat_next;
    end
  end

  // Step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_step <= '0;
      wr_step <= '0;
    end else begin
      rd_step <= (state == ST_READ) ? rd_step + 3'd1 : '0;
      wr_step <= (state == ST_WRITE) ? wr_step + STEP_W'(1) : '0;
    end
  end

  // Read addresses
  always_comb begin
    e_rd_addr = te;
    f_rd_addr = tf;
    if (it_mode == MODE_SPLIT_FACE) begin
      case (rd_step)
        3'd1:    e_rd_addr = fedge_q;
        3'd2:    e_rd_addr = enext_q;
        3'd3:    e_rd_addr = enext_q;
        default: e_rd_addr = te;
      endcase
    end else begin
      case (rd_step)
        3'd1:    e_rd_addr = etwin_q;
        3'd2:    e_rd_addr = r_ep;
        3'd3:    e_rd_addr = r_tp;
        default: e_rd_addr = te;
      endcase
    end
  end

  // Capture read data
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      if (it_mode == MODE_SPLIT_FACE) begin
        case (rd_step)
          3'd1: s_e0 <= fedge_q;
          3'd2: begin s_e1 <= enext_q; s_v0 <= eorg_q; end
          3'd3: begin s_e2 <= enext_q; s_v1 <= eorg_q; end
          3'd4: s_v2 <= eorg_q;
          default: s_e0 <= s_e0;
        endcase
      end else begin
        case (rd_step)
          3'd1: begin
            r_et <= etwin_q; r_en <= enext_q; r_ep <= eprev_q;
            r_a  <= eorg_q;  r_f0 <= eface_q;
          end
          3'd2: begin
            r_tn <= enext_q; r_tp <= eprev_q; r_b <= eorg_q; r_f1 <= eface_q;
          end
          3'd3: r_c <= eorg_q;
          3'd4: r_d <= eorg_q;
          default: r_c <= r_c;
        endcase
      end
    end
  end

  // Write sequence: one half-edge per step, vertex and face writes alongside
  always_comb begin
    v_we_xy = 1'b0; v_we_e = 1'b0; v_addr = '0; v_x = '0; v_y = '0; v_e = '0;
    e_we_org = 1'b0; e_we_twin = 1'b0; e_we_lnk = 1'b0; e_wr_addr = '0;
    e_org = '0; e_twin = '0; e_next = '0; e_prev = '0; e_face = '0;
    f_we_e = 1'b0; f_we_inf = 1'b0; f_wr_addr = '0; f_e = '0; f_inf = 1'b0;
    if (state == ST_WRITE) begin
      case (it_mode)
        MODE_INIT: begin
          e_we_org = 1'b1; e_we_twin = 1'b1; e_wr_addr = ebase + EIW'(wr_step);
          case (wr_step)
            5'd0: begin
              e_org = vo[1]; e_twin = eo[1]; e_we_lnk = 1'b1;
              e_next = eo[2]; e_prev = eo[4]; e_face = fo[0];
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vo[0]; v_e = eo[6];
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[0]; f_e = eo[0];
            end
            5'd1: begin
              e_org = vo[2]; e_twin = eo[0]; e_we_lnk = 1'b1;
              e_next = eo[8]; e_prev = eo[6]; e_face = fo[1];
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vo[1]; v_e = eo[0];
              v_x = it_px; v_y = it_py;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[1]; f_e = eo[6]; f_inf = 1'b1;
            end
            5'd2: begin
              e_org = vo[2]; e_twin = eo[3]; e_we_lnk = 1'b1;
              e_next = eo[4]; e_prev = eo[0]; e_face = fo[0];
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vo[2]; v_e = eo[2];
              v_x = it_sx; v_y = it_sy;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[2]; f_e = eo[10]; f_inf = 1'b1;
            end
            5'd3: begin
              e_org = vo[3]; e_twin = eo[2]; e_we_lnk = 1'b1;
              e_next = eo[12]; e_prev = eo[10]; e_face = fo[2];
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vo[3]; v_e = eo[4];
              v_x = it_tx; v_y = it_ty;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[3]; f_e = eo[14]; f_inf = 1'b1;
            end
            5'd4: begin
              e_org = vo[3]; e_twin = eo[5]; e_we_lnk = 1'b1;
              e_next = eo[0]; e_prev = eo[2]; e_face = fo[0];
            end
            5'd5: begin
              e_org = vo[1]; e_twin = eo[4]; e_we_lnk = 1'b1;
              e_next = eo[16]; e_prev = eo[14]; e_face = fo[3];
            end
            5'd6: begin
              e_org = vo[0]; e_twin = eo[12]; e_we_lnk = 1'b1;
              e_next = eo[1]; e_prev = eo[8]; e_face = fo[1];
            end
            5'd7:  begin e_org = vo[2]; e_twin = eo[13]; end
            5'd8: begin
              e_org = vo[1]; e_twin = eo[14]; e_we_lnk = 1'b1;
              e_next = eo[6]; e_prev = eo[1]; e_face = fo[1];
            end
            5'd9:  begin e_org = vo[0]; e_twin = eo[15]; end
            5'd10: begin
              e_org = vo[0]; e_twin = eo[16]; e_we_lnk = 1'b1;
              e_next = eo[3]; e_prev = eo[12]; e_face = fo[2];
            end
            5'd11: begin e_org = vo[3]; e_twin = eo[17]; end
            5'd12: begin
              e_org = vo[2]; e_twin = eo[6]; e_we_lnk = 1'b1;
              e_next = eo[10]; e_prev = eo[3]; e_face = fo[2];
            end
            5'd13: begin e_org = vo[0]; e_twin = eo[7]; end
            5'd14: begin
              e_org = vo[0]; e_twin = eo[8]; e_we_lnk = 1'b1;
              e_next = eo[5]; e_prev = eo[16]; e_face = fo[3];
            end
            5'd15: begin e_org = vo[1]; e_twin = eo[9]; end
            5'd16: begin
              e_org = vo[3]; e_twin = eo[10]; e_we_lnk = 1'b1;
              e_next = eo[14]; e_prev = eo[5]; e_face = fo[3];
            end
            5'd17: begin e_org = vo[0]; e_twin = eo[11]; end
            default: e_we_org = 1'b0;
          endcase
        end

        MODE_SPLIT_FACE: begin
          e_we_lnk = 1'b1;
          case (wr_step)
            5'd0: begin
              e_wr_addr = eo[0]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = s_v1; e_twin = eo[1]; e_face = tf; e_next = eo[5]; e_prev = s_e0;
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vbase; v_e = eo[1];
              v_x = it_px; v_y = it_py;
              f_we_e = 1'b1; f_wr_addr = tf; f_e = s_e0;
            end
            5'd1: begin
              e_wr_addr = eo[1]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[0]; e_face = fo[0]; e_next = s_e1; e_prev = eo[2];
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[0]; f_e = s_e1; f_inf = sf_inf;
            end
            5'd2: begin
              e_wr_addr = eo[2]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = s_v2; e_twin = eo[3]; e_face = fo[0]; e_next = eo[1]; e_prev = s_e1;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[1]; f_e = s_e2; f_inf = sf_inf;
            end
            5'd3: begin
              e_wr_addr = eo[3]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[2]; e_face = fo[1]; e_next = s_e2; e_prev = eo[4];
            end
            5'd4: begin
              e_wr_addr = eo[4]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = s_v0; e_twin = eo[5]; e_face = fo[1]; e_next = eo[3]; e_prev = s_e2;
            end
            5'd5: begin
              e_wr_addr = eo[5]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[4]; e_face = tf; e_next = s_e0; e_prev = eo[0];
            end
            5'd6: begin
              e_wr_addr = s_e0; e_face = tf; e_next = eo[0]; e_prev = eo[5];
            end
            5'd7: begin
              e_wr_addr = s_e1; e_face = fo[0]; e_next = eo[2]; e_prev = eo[1];
            end
            5'd8: begin
              e_wr_addr = s_e2; e_face = fo[1]; e_next = eo[4]; e_prev = eo[3];
            end
            default: e_we_lnk = 1'b0;
          endcase
        end

        MODE_FLIP: begin
          e_we_lnk = 1'b1;
          case (wr_step)
            5'd0: begin
              e_wr_addr = r_tn; e_face = r_f0; e_next = r_et; e_prev = r_ep;
              v_we_e = 1'b1; v_addr = r_a; v_e = r_tn;
              f_we_e = 1'b1; f_wr_addr = r_f0; f_e = r_tn;
            end
            5'd1: begin
              e_wr_addr = r_et; e_we_org = 1'b1; e_org = r_d;
              e_face = r_f0; e_next = r_ep; e_prev = r_tn;
              v_we_e = 1'b1; v_addr = r_b; v_e = r_en;
              f_we_e = 1'b1; f_wr_addr = r_f1; f_e = r_en;
            end
            5'd2: begin
              e_wr_addr = r_ep; e_face = r_f0; e_next = r_tn; e_prev = r_et;
            end
            5'd3: begin
              e_wr_addr = r_en; e_face = r_f1; e_next = te; e_prev = r_tp;
            end
            5'd4: begin
              e_wr_addr = te; e_we_org = 1'b1; e_org = r_c;
              e_face = r_f1; e_next = r_tp; e_prev = r_en;
            end
            5'd5: begin
              e_wr_addr = r_tp; e_face = r_f1; e_next = r_en; e_prev = te;
            end
            default: e_we_lnk = 1'b0;
          endcase
        end

        MODE_SPLIT_EDGE: begin
          e_we_lnk = 1'b1;
          case (wr_step)
            5'd0: begin
              e_wr_addr = eo[0]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[1]; e_face = fo[0]; e_next = r_en; e_prev = eo[3];
              v_we_xy = 1'b1; v_we_e = 1'b1; v_addr = vbase; v_e = eo[2];
              v_x = it_px; v_y = it_py;
              f_we_e = 1'b1; f_wr_addr = r_f0; f_e = te;
            end
            5'd1: begin
              e_wr_addr = eo[1]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = r_b; e_twin = eo[0]; e_face = r_f1; e_next = eo[4]; e_prev = r_tp;
              v_we_e = 1'b1; v_addr = r_a; v_e = te;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[0]; f_e = eo[0];
            end
            5'd2: begin
              e_wr_addr = eo[2]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[3]; e_face = r_f0; e_next = r_ep; e_prev = te;
              v_we_e = 1'b1; v_addr = r_b; v_e = eo[1];
              f_we_e = 1'b1; f_wr_addr = r_f1; f_e = eo[1];
            end
            5'd3: begin
              e_wr_addr = eo[3]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = r_c; e_twin = eo[2]; e_face = fo[0]; e_next = eo[0]; e_prev = r_en;
              f_we_e = 1'b1; f_we_inf = 1'b1; f_wr_addr = fo[1]; f_e = r_et;
            end
            5'd4: begin
              e_wr_addr = eo[4]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = vbase; e_twin = eo[5]; e_face = r_f1; e_next = r_tp; e_prev = eo[1];
            end
            5'd5: begin
              e_wr_addr = eo[5]; e_we_org = 1'b1; e_we_twin = 1'b1;
              e_org = r_d; e_twin = eo[4]; e_face = fo[1]; e_next = r_et; e_prev = r_tn;
            end
            5'd6: begin
              e_wr_addr = te; e_face = r_f0; e_next = eo[2]; e_prev = r_ep;
            end
            5'd7: begin
              e_wr_addr = r_ep; e_face = r_f0; e_next = te; e_prev = eo[2];
            end
            5'd8: begin
              e_wr_addr = r_en; e_face = fo[0]; e_next = eo[3]; e_prev = eo[0];
            end
            5'd9: begin
              e_wr_addr = r_tp; e_face = r_f1; e_next = eo[1]; e_prev = eo[4];
            end
            5'd10: begin
              e_wr_addr = r_et; e_we_org = 1'b1; e_org = vbase;
              e_face = fo[1]; e_next = r_tn; e_prev = eo[5];
            end
            5'd11: begin
              e_wr_addr = r_tn; e_face = fo[1]; e_next = eo[5]; e_prev = r_et;
            end
            default: e_we_lnk = 1'b0;
          endcase
        end

        default: e_we_lnk = 1'b0;
      endcase
    end
  end

  assign e_addr = (state == ST_WRITE) ? e_wr_addr : e_rd_addr;
  assign f_addr = (state == ST_WRITE) ? f_wr_addr : f_rd_addr;

  // Counter update at the end of a successful write sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= '0;
      half_edge_count <= '0;
      face_count      <= '0;
      inf_vid         <= '0;
    end else if (state == ST_WRITE && wr_last) begin
      case (it_mode)
        MODE_INIT: begin
          vertex_count    <= vertex_count + VCW'(4);
          half_edge_count <= half_edge_count + ECW'(18);
          face_count      <= face_count + FCW'(4);
          inf_vid         <= vbase;
        end
        MODE_SPLIT_FACE, MODE_SPLIT_EDGE: begin
          vertex_count    <= vertex_count + VCW'(1);
          half_edge_count <= half_edge_count + ECW'(6);
          face_count      <= face_count + FCW'(2);
        end
        default: inf_vid <= inf_vid;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      out_idx  <= res_idx;
      out_stat <= res_stat;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_index = out_idx;
  assign out_ch.status       = out_stat;

  // Tables
  hemu_ram #(.WIDTH(COORD_WIDTH), .DEPTH(VERTEX_DEPTH)) u_vx (
    .clk(clk), .we(v_we_xy), .addr(v_addr), .wdata(v_x), .rdata());
  hemu_ram #(.WIDTH(COORD_WIDTH), .DEPTH(VERTEX_DEPTH)) u_vy (
    .clk(clk), .we(v_we_xy), .addr(v_addr), .wdata(v_y), .rdata());
  hemu_ram #(.WIDTH(EIW), .DEPTH(VERTEX_DEPTH)) u_vedge (
    .clk(clk), .we(v_we_e), .addr(v_addr), .wdata(v_e), .rdata());
  hemu_ram #(.WIDTH(VIW), .DEPTH(HALF_EDGE_DEPTH)) u_eorg (
    .clk(clk), .we(e_we_org), .addr(e_addr), .wdata(e_org), .rdata(eorg_q));
  hemu_ram #(.WIDTH(EIW), .DEPTH(HALF_EDGE_DEPTH)) u_etwin (
    .clk(clk), .we(e_we_twin), .addr(e_addr), .wdata(e_twin), .rdata(etwin_q));
  hemu_ram #(.WIDTH(EIW), .DEPTH(HALF_EDGE_DEPTH)) u_enext (
    .clk(clk), .we(e_we_lnk), .addr(e_addr), .wdata(e_next), .rdata(enext_q));
  hemu_ram #(.WIDTH(EIW), .DEPTH(HALF_EDGE_DEPTH)) u_eprev (
    .clk(clk), .we(e_we_lnk), .addr(e_addr), .wdata(e_prev), .rdata(eprev_q));
  hemu_ram #(.WIDTH(FIW), .DEPTH(HALF_EDGE_DEPTH)) u_eface (
    .clk(clk), .we(e_we_lnk), .addr(e_addr), .wdata(e_face), .rdata(eface_q));
  hemu_ram #(.WIDTH(EIW), .DEPTH(FACE_DEPTH)) u_fedge (
    .clk(clk), .we(f_we_e), .addr(f_addr), .wdata(f_e), .rdata(fedge_q));
  hemu_ram #(.WIDTH(1), .DEPTH(FACE_DEPTH)) u_finf (
    .clk(clk), .we(f_we_inf), .addr(f_addr), .wdata(f_inf), .rdata(finf_q));

  // Face flags are write-only here; keep the read port observed
  logic finf_seen;
  always_ff @(posedge clk) begin
    finf_seen <= finf_q;
  end

`ifndef SYNTH
  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= VCW'(VERTEX_DEPTH) && half_edge_count <= ECW'(HALF_EDGE_DEPTH) &&
    face_count <= FCW'(FACE_DEPTH))
    else $error("table count beyond depth");
  a_pairs_even: assert property (@(posedge clk) disable iff (rst)
    half_edge_count[0] == 1'b0)
    else $error("half-edge count not even");
  a_write_only_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> res_stat == STAT_OK)
    else $error("write sequence on rejected item");
  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(vertex_count) |-> $past(state) == ST_WRITE)
    else $error("vertex count moved outside write sequence");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result without finished operation");
`endif

endmodule

/* src/hemu_ram.sv */
module hemu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
